FILE: design/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and codes for the LIFO stack with dump
// Opcodes, result kinds and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lsd_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TOP  = 2'd2,
    OP_DUMP = 2'd3
  } opcode_t;

  localparam logic [2:0] KIND_TOP   = 3'd0;
  localparam logic [2:0] KIND_ENTRY = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_FULL  = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic       push;       // write push_value on top, grow the stack
    logic       pop;        // shrink the stack by one
    logic       rd_top;     // read the top entry
    logic       dump_init;  // load the walk pointer with the fill count
    logic       dump_step;  // read the entry below the walk pointer and step down
    logic       emit;       // load the result registers
    logic [2:0] kind;
    logic       use_rd;     // result value comes from the read data
    logic       last;
  } lsd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_done;  // walk pointer reached the bottom
    logic pend;       // read data from a walk step is ready
  } lsd_stat_t;

endpackage

FILE: design/lifo_stack_with_dump_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_dump_unit: byte-wide LIFO stack with dump
// Push, pop, read-top and dump commands on a DEPTH-entry stack of bytes.
//
//   channel   dir  handshake              payload
//   command   in   start & !busy          opcode, push_value
//   result    out  strobe (one cycle)     kind, value, last
//
// Push and pop hold busy low. A push on a full stack, or any other
// command on an empty stack, puts its status result out on the next
// cycle. Read top is a registered memory read, then the result. Dump
// does one read per cycle from the single memory read port, then puts
// out the end marker. Each result sits on the ports in the cycle after
// the controller cycle that produces it.
// Reset (rst, synchronous) empties the stack; entry contents are not cleared.
// The receiver cannot stall: each result sits on the ports for one cycle only.
// ----------------------------------------------------------------------------
module lifo_stack_with_dump_unit import lsd_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode,
  input  logic [7:0] push_value,
  output logic       strobe,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       last
);

  lsd_cmd_t  cmd;
  lsd_stat_t stat;

  // Sequencing: decode the transaction, walk the stack for a dump
  lsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode_t'(opcode)),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Storage, fill count and the registered result port
  lsd_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (push_value),
    .stat       (stat),
    .strobe     (strobe),
    .kind       (kind),
    .value      (value),
    .last       (last)
  );

endmodule

FILE: design/lsd_dpath.sv
// ----------------------------------------------------------------------------
// lsd_dpath: stack storage and result registers
// Entry memory with registered read, fill count, dump walk pointer and
// the registered result port.
// ----------------------------------------------------------------------------
module lsd_dpath import lsd_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  lsd_cmd_t   cmd,
  input  logic [7:0] push_value,
  output lsd_stat_t  stat,
  output logic       strobe,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]    mem [0:DEPTH-1];
  logic [CW-1:0] fill;
  logic [CW-1:0] ptr;
  logic          pend;
  logic [7:0]    rd_data;
  logic [CW-1:0] fill_m1;
  logic [CW-1:0] ptr_m1;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          walk_done;

  assign fill_m1   = fill - 1'b1;
  assign ptr_m1    = ptr - 1'b1;
  assign walk_done = (ptr == '0);
  assign rd_addr   = cmd.rd_top ? fill_m1[AW-1:0] : ptr_m1[AW-1:0];
  assign rd_en     = cmd.rd_top | (cmd.dump_step & ~walk_done);

  assign stat.empty     = (fill == '0);
  assign stat.full      = (fill == CW'(DEPTH));
  assign stat.walk_done = walk_done;
  assign stat.pend      = pend;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[fill[AW-1:0]] <= push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      ptr  <= '0;
      pend <= 1'b0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 1'b1;
      end else if (cmd.pop) begin
        fill <= fill_m1;
      end
      if (cmd.dump_init) begin
        ptr <= fill;
      end else if (cmd.dump_step && !walk_done) begin
        ptr <= ptr_m1;
      end
      pend <= cmd.dump_step & ~walk_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind  <= cmd.kind;
      value <= cmd.use_rd ? rd_data : 8'd0;
      last  <= cmd.last;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full)
    else $error("push issued on a full stack");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= fill)
    else $error("walk pointer above fill count");

endmodule

FILE: design/lsd_ctrl.sv
// ----------------------------------------------------------------------------
// lsd_ctrl: command decode and sequencing
// Decodes an accepted transaction and drives the datapath through the
// read-top and dump sequences.
// ----------------------------------------------------------------------------
module lsd_ctrl import lsd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  opcode_t   opcode,
  input  lsd_stat_t stat,
  output lsd_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TOP  = 4'b0010,
    S_DUMP = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_PUSH: begin
              if (stat.full) begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_FULL;
                cmd.last = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
            end
            OP_POP, OP_TOP, OP_DUMP: begin
              if (stat.empty) begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_EMPTY;
                cmd.last = 1'b1;
              end else if (opcode == OP_POP) begin
                cmd.pop = 1'b1;
              end else if (opcode == OP_TOP) begin
                cmd.rd_top = 1'b1;
                state_next = S_TOP;
              end else begin
                cmd.dump_init = 1'b1;
                state_next    = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_TOP: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_TOP;
        cmd.use_rd = 1'b1;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_DUMP: begin
        cmd.dump_step = 1'b1;
        if (stat.pend) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_ENTRY;
          cmd.use_rd = 1'b1;
        end
        if (stat.walk_done) begin
          state_next = S_END;
        end
      end
      S_END: begin
        cmd.emit   = 1'b1;
        cmd.kind   = KIND_END;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(cmd.emit) && $past(cmd.last))
    else $error("sequence ended without a final result");

  a_pend_follows_step: assert property (@(posedge clk) disable iff (rst)
    stat.pend |-> state == S_DUMP)
    else $error("walk read data outside the dump sequence");

endmodule

FILE: sim/tb_lifo_stack_with_dump_unit.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_dump_unit: self-checking bench for the LIFO stack
// Sends push, pop, read-top and dump commands and checks every result
// against a stack model kept in the bench. It starts with a short command
// table (empty and full stacks, extreme bytes) and then runs random traffic,
// biased in blocks so that the stack both fills up and drains. Sender idle
// cycles are random, with one long stretch that has no idle cycles.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_dump_unit;
  import lsd_pkg::*;

  localparam int DEPTH    = 32;
  localparam int N_RANDOM = 420;
  localparam int TIMEOUT  = 2_000_000;
  localparam int SETTLE   = DEPTH + 8;    // longest dump walk plus margin
  localparam int MAX_SHOWN = 10;

  // One result as seen on the strobe port
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } result_t;

  // One row of the directed command table. A row with reps > 1 sends its
  // command reps times, with consecutive bytes starting at val. Rows with a
  // typed result carry it in want; the rest rely on the stack model.
  typedef struct packed {
    opcode_t    op;
    logic [7:0] val;
    logic [6:0] reps;
    logic       typed;
    result_t    want;
  } cmd_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] opcode;
  logic [7:0] push_value;
  logic       strobe;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  // Stack model state
  logic [7:0] model_mem [DEPTH];
  int         model_fill;

  result_t    step_results[$];      // results of the latest transaction
  result_t    pending_results[$];   // results still owed by the block
  cmd_row_t   script[$];

  int  mismatches;
  int  n_items;
  int  n_results;
  int  n_full;
  int  n_empty;
  int  n_dumps;
  int  deepest;
  bit  idle_on;
  int  push_pct;

  result_t got;
  result_t want_now;

  lifo_stack_with_dump_unit #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .push_value (push_value),
    .strobe     (strobe),
    .kind       (kind),
    .value      (value),
    .last       (last)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs or stops producing results
  initial begin
    #(TIMEOUT);
    $display("timeout: %0d results still pending", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic result_t mk_result(logic [2:0] k, logic [7:0] v, logic l);
    result_t r;
    r.kind  = k;
    r.value = v;
    r.last  = l;
    return r;
  endfunction

  function automatic cmd_row_t row(opcode_t op, logic [7:0] val, int reps,
                                   logic typed, logic [2:0] k, logic [7:0] v);
    cmd_row_t c;
    c.op    = op;
    c.val   = val;
    c.reps  = reps[6:0];
    c.typed = typed;
    c.want  = mk_result(k, v, 1'b1);
    return c;
  endfunction

  // Work out what one command does to the stack and which results it owes.
  // Leaves the results in step_results, top of stack first for a dump.
  task automatic stack_outcome(input opcode_t op, input logic [7:0] val);
    step_results.delete();
    if (op == OP_PUSH) begin
      if (model_fill >= DEPTH) begin
        // full stack: drop the byte, report full
        step_results.push_back(mk_result(KIND_FULL, 8'h00, 1'b1));
      end else begin
        model_mem[model_fill] = val;
        model_fill++;
        if (model_fill > deepest) deepest = model_fill;
      end
    end else if (model_fill == 0) begin
      // pop, read top and dump all report empty on an empty stack
      step_results.push_back(mk_result(KIND_EMPTY, 8'h00, 1'b1));
    end else begin
      case (op)
        OP_POP: model_fill--;
        OP_TOP: step_results.push_back(mk_result(KIND_TOP, model_mem[model_fill-1], 1'b1));
        default: begin
          for (int i = model_fill - 1; i >= 0; i--)
            step_results.push_back(mk_result(KIND_ENTRY, model_mem[i], 1'b0));
          step_results.push_back(mk_result(KIND_END, 8'h00, 1'b1));
        end
      endcase
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Issue one command transaction. Start stays high on return so that a
  // following command can go out back to back; callers that stop sending
  // must lower it themselves.
  task automatic send_cmd(input opcode_t op, input logic [7:0] val,
                          input logic typed, input result_t want);
    // insert random idle cycles on the command side
    while (idle_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    push_value <= val;
    // hold the command until an edge sees start high and busy low
    do @(posedge clk); while (busy);
    stack_outcome(op, val);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      for (int k = 0; k < step_results.size(); k++)
        pending_results.push_back(step_results[k]);
    end
    n_items++;
  endtask

  // Hold off the command side until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: the block cannot be stalled, so take a result on
  // every edge that sees the strobe and match it with the oldest owed one.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      got = mk_result(kind, value, last);
      n_results++;
      if (got.kind == KIND_FULL)  n_full++;
      if (got.kind == KIND_EMPTY) n_empty++;
      if (got.kind == KIND_END)   n_dumps++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind=%0d value=%02h last=%0d",
                                got.kind, got.value, got.last));
      end else begin
        want_now = pending_results.pop_front();
        if (got.kind !== want_now.kind)
          note_mismatch($sformatf("kind: expected %0d, got %0d",
                                  want_now.kind, got.kind));
        if (got.value !== want_now.value)
          note_mismatch($sformatf("value: expected %02h, got %02h (kind %0d)",
                                  want_now.value, got.value, want_now.kind));
        if (got.last !== want_now.last)
          note_mismatch($sformatf("last: expected %0d, got %0d (kind %0d)",
                                  want_now.last, got.last, want_now.kind));
      end
    end
  end

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    opcode     = OP_PUSH;
    push_value = 8'h00;
    model_fill = 0;
    mismatches = 0;
    n_items    = 0;
    n_results  = 0;
    n_full     = 0;
    n_empty    = 0;
    n_dumps    = 0;
    deepest    = 0;
    idle_on    = 1'b1;
    push_pct   = 50;

    // Directed table: empty-stack reports, extreme bytes, a full stack
    // with a dropped push, the longest dump, and draining back to empty.
    script.push_back(row(OP_POP,  8'hFF, 1, 1'b1, KIND_EMPTY, 8'h00));
    script.push_back(row(OP_TOP,  8'h00, 1, 1'b1, KIND_EMPTY, 8'h00));
    script.push_back(row(OP_DUMP, 8'hAA, 1, 1'b1, KIND_EMPTY, 8'h00));
    script.push_back(row(OP_PUSH, 8'h00, 1, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_TOP,  8'h55, 1, 1'b1, KIND_TOP,   8'h00));
    script.push_back(row(OP_PUSH, 8'hFF, 1, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_TOP,  8'h00, 1, 1'b1, KIND_TOP,   8'hFF));
    script.push_back(row(OP_DUMP, 8'h00, 1, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_POP,  8'h00, 2, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_POP,  8'h00, 1, 1'b1, KIND_EMPTY, 8'h00));
    // fill to the brim with E0..FF, then overflow by one
    script.push_back(row(OP_PUSH, 8'hE0, DEPTH, 1'b0, KIND_TOP, 8'h00));
    script.push_back(row(OP_PUSH, 8'h5A, 1, 1'b1, KIND_FULL,  8'h00));
    script.push_back(row(OP_TOP,  8'hFF, 1, 1'b1, KIND_TOP,   8'hFF));
    script.push_back(row(OP_DUMP, 8'h00, 1, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_POP,  8'hFF, DEPTH, 1'b0, KIND_TOP, 8'h00));
    script.push_back(row(OP_DUMP, 8'h00, 1, 1'b1, KIND_EMPTY, 8'h00));
    script.push_back(row(OP_PUSH, 8'h3C, 1, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_DUMP, 8'hC3, 1, 1'b0, KIND_TOP,   8'h00));
    script.push_back(row(OP_POP,  8'h00, 1, 1'b0, KIND_TOP,   8'h00));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < script.size(); r++) begin
      for (int k = 0; k < script[r].reps; k++)
        send_cmd(script[r].op, script[r].val + 8'(k), script[r].typed, script[r].want);
    end

    // let the directed part settle completely before going random
    drain_results();

    // Random traffic. Re-pick the push bias every 40 commands so the stack
    // swings between empty and full; run a long stretch without idling.
    for (int n = 0; n < N_RANDOM; n++) begin
      opcode_t    op;
      logic [7:0] val;
      int         pick;

      if (n % 40 == 0) begin
        case ($urandom_range(3))
          0:       push_pct = 10;
          1:       push_pct = 45;
          2:       push_pct = 75;
          default: push_pct = 95;
        endcase
      end
      if (n == 150) idle_on = 1'b0;
      if (n == 300) idle_on = 1'b1;
      if (n % 125 == 124) drain_results();

      pick = $urandom_range(99);
      if (pick < push_pct) begin
        op = OP_PUSH;
      end else begin
        pick = $urandom_range(9);
        if (pick < 5)      op = OP_POP;
        else if (pick < 8) op = OP_TOP;
        else               op = OP_DUMP;
      end
      case ($urandom_range(9))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        default: val = 8'($urandom_range(255));
      endcase
      send_cmd(op, val, 1'b0, mk_result(KIND_TOP, 8'h00, 1'b0));
    end

    // stop sending, wait for the last results, then watch for strays
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("ran %0d commands, checked %0d results (%0d dumps, %0d empty, %0d full)",
             n_items, n_results, n_dumps, n_empty, n_full);
    $display("deepest stack seen: %0d of %0d entries, mismatches: %0d",
             deepest, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
